/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/lcdns_pkg.sv */
// Types, codes and constants of the character LCD nibble sequencer.
// No dependencies; used by all sequencer modules.
package lcdns_pkg;

    // Request type codes
    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_CMD    = 2'd1;
    localparam logic [1:0] REQ_DATA   = 2'd2;
    localparam logic [1:0] REQ_CURSOR = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE_PULSE = 2'd0;
    localparam logic [1:0] CFG_BYTE_WAIT    = 2'd1;
    localparam logic [1:0] CFG_SLOW_WAIT    = 2'd2;
    localparam logic [1:0] CFG_POWER_ON     = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  BYTE_WAIT_RESET  = 8'd50;
    localparam logic [15:0] SLOW_WAIT_RESET  = 16'd2000;
    localparam logic [15:0] POWER_ON_RESET   = 16'd50000;

    // Controller command codes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

    // Init sequence timing and nibbles
    localparam logic [15:0] INIT_FIRST_WAIT  = 16'd5000;
    localparam logic [15:0] INIT_SECOND_WAIT = 16'd150;
    localparam logic [3:0]  INIT_WAKE_NIBBLE = 4'h3;
    localparam logic [3:0]  INIT_4BIT_NIBBLE = 4'h2;

    // Step positions within a request
    localparam logic [3:0] INIT_NIBBLE_STEPS = 4'd4;
    localparam logic [3:0] INIT_LAST_STEP    = 4'd13;
    localparam logic [3:0] BYTE_LAST_STEP    = 4'd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_value;
        logic       cursor_row;
        logic [5:0] cursor_col;
    } req_word_t;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic [15:0] wait_before_us;
        logic [15:0] wait_after_us;
        logic        last;
    } res_word_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       load_res;
        logic [3:0] step;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_step;
    } dp_status_t;

    // Command bytes sent after the init wake-up nibbles
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_FUNC_4BIT;
            3'd1:    b = CMD_DISP_OFF;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_ENTRY;
            default: b = CMD_DISP_ON;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/lcdns_ctrl.sv */
// Controller of the nibble sequencer: request handshake, step count, result valid.
// Depends on lcdns_pkg.
module lcdns_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output lcdns_pkg::dp_cmd_t    cmd,
    input  lcdns_pkg::dp_status_t status
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       res_valid_reg, res_valid_next;
    logic       advance;

    // Move one step when the output register is free or being emptied
    assign advance   = (state_reg == ST_RUN) && (!res_valid_reg || res_ready);
    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;

    assign cmd.load_req = req_valid && req_ready;
    assign cmd.load_res = advance;
    assign cmd.step     = step_reg;

    // Next state and step
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = 4'd0;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    res_valid_next = 1'b1;
                    if (status.last_step)
                    begin
                        state_next = ST_IDLE;
                        step_next  = 4'd0;
                    end
                    else
                    begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

/* hw/rtl/lcdns_dpath.sv */
// Datapath of the nibble sequencer: configuration, request hold and result build.
// Depends on lcdns_pkg.
module lcdns_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  lcdns_pkg::req_word_t  req,
    input  lcdns_pkg::dp_cmd_t    cmd,
    output lcdns_pkg::dp_status_t status,
    output lcdns_pkg::res_word_t  res
);

    logic [7:0]  byte_wait_reg;
    logic [15:0] slow_wait_reg;
    logic [15:0] power_on_reg;

    lcdns_pkg::req_word_t req_reg;
    lcdns_pkg::res_word_t res_reg, res_next;

    logic        is_init;
    logic        wake_step;
    logic [3:0]  init_off;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic        clr_home;
    logic [16:0] slow_sum;
    logic [15:0] slow_total;
    logic [15:0] byte_wait16;

    // Configuration registers; enable timing is handled downstream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_wait_reg <= lcdns_pkg::BYTE_WAIT_RESET;
            slow_wait_reg <= lcdns_pkg::SLOW_WAIT_RESET;
            power_on_reg  <= lcdns_pkg::POWER_ON_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcdns_pkg::CFG_BYTE_WAIT: byte_wait_reg <= cfg_wdata[7:0];
                lcdns_pkg::CFG_SLOW_WAIT: slow_wait_reg <= cfg_wdata;
                lcdns_pkg::CFG_POWER_ON:  power_on_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the request word and load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign is_init   = (req_reg.req_type == lcdns_pkg::REQ_INIT);
    assign wake_step = is_init && (cmd.step < lcdns_pkg::INIT_NIBBLE_STEPS);
    assign init_off  = cmd.step - lcdns_pkg::INIT_NIBBLE_STEPS;

    // Pick the byte being sent and its RS level
    always_comb
    begin
        cur_rs = 1'b0;
        case (req_reg.req_type)
            lcdns_pkg::REQ_INIT:   cur_byte = lcdns_pkg::init_cmd(init_off[3:1]);
            lcdns_pkg::REQ_CMD:    cur_byte = req_reg.byte_value;
            lcdns_pkg::REQ_DATA:
            begin
                cur_byte = req_reg.byte_value;
                cur_rs   = 1'b1;
            end
            default:
                // DDRAM address: row 1 sits at offset 0x40, column fits below it
                cur_byte = {1'b1, req_reg.cursor_row, req_reg.cursor_col};
        endcase
    end

    // Clear and home add the slow wait, saturating
    assign clr_home    = !cur_rs && ((cur_byte == lcdns_pkg::CMD_CLEAR) ||
                                     (cur_byte == lcdns_pkg::CMD_HOME));
    assign byte_wait16 = {8'd0, byte_wait_reg};
    assign slow_sum    = {9'd0, byte_wait_reg} + {1'b0, slow_wait_reg};
    assign slow_total  = slow_sum[16] ? 16'hFFFF : slow_sum[15:0];

    assign status.last_step = is_init ? (cmd.step == lcdns_pkg::INIT_LAST_STEP)
                                      : (cmd.step == lcdns_pkg::BYTE_LAST_STEP);

    // Build the result word for the current step
    always_comb
    begin
        res_next.last           = status.last_step;
        res_next.wait_before_us = 16'd0;
        if (wake_step)
        begin
            res_next.reg_select = 1'b0;
            res_next.nibble     = (cmd.step == 4'd3) ? lcdns_pkg::INIT_4BIT_NIBBLE
                                                     : lcdns_pkg::INIT_WAKE_NIBBLE;
            case (cmd.step)
                4'd0:
                begin
                    res_next.wait_before_us = power_on_reg;
                    res_next.wait_after_us  = lcdns_pkg::INIT_FIRST_WAIT;
                end
                4'd1:    res_next.wait_after_us = lcdns_pkg::INIT_SECOND_WAIT;
                default: res_next.wait_after_us = byte_wait16;
            endcase
        end
        else
        begin
            // Even steps carry the high nibble, odd steps the low nibble
            res_next.reg_select = cur_rs;
            if (cmd.step[0])
            begin
                res_next.nibble        = cur_byte[3:0];
                res_next.wait_after_us = clr_home ? slow_total : byte_wait16;
            end
            else
            begin
                res_next.nibble        = cur_byte[7:4];
                res_next.wait_after_us = 16'd0;
            end
        end
    end

    assign res = res_reg;

endmodule

/* hw/rtl/char_lcd_nibble_sequencer.sv */
// Top level of the character LCD nibble sequencer (4-bit bus).
// Depends on lcdns_pkg, lcdns_ctrl and lcdns_dpath.
//
// Usage:
//   req channel (req_valid/req_ready, req word): one request per word,
//   init, command byte, data byte or set cursor.
//   res channel (res_valid/res_ready, res word): one enable pulse per word,
//   with nibble, RS level, waits before and after, and last on the final one.
//   cfg port (cfg_we, cfg_index, cfg_wdata): write while idle; index 0 is
//   the enable pulse time, 1 byte wait, 2 slow wait, 3 power-on wait.
// Timing:
//   The request word and the run state are registered first; the first
//   result word is then loaded into the output register. The step counter
//   in the controller emits one word per cycle while the receiver is ready.
//   A new request is taken once the last word sits in the output register.
// Reset: all requests are dropped, no result is valid, and the wait registers
// return to 50, 2000 and 50000 us (byte, slow and power-on wait).
// Stall: while res_ready is low the output word holds and the step count
// waits; no word is lost.
module char_lcd_nibble_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  lcdns_pkg::req_word_t req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lcdns_pkg::res_word_t res
);

    lcdns_pkg::dp_cmd_t    cmd;
    lcdns_pkg::dp_status_t status;

    // Sequence control
    lcdns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Result generation
    lcdns_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .res       (res)
    );

endmodule

/* hw/rtl/lcdns_checker.sv */
// Port-level checks of the nibble sequencer, bound to the top level.
// Depends on lcdns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdns_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input lcdns_pkg::req_word_t req,
    input logic                 res_valid,
    input logic                 res_ready,
    input lcdns_pkg::res_word_t res
);

    // A stalled result word holds
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))

    // One request at a time: busy right after a request is taken
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

    // Only the first wake-up nibble carries a wait before it
    `ASSERT_IMP(a_wait_before, clk, rst_n, res_valid && (res.wait_before_us != 16'd0),
        (res.nibble == lcdns_pkg::INIT_WAKE_NIBBLE) && !res.reg_select && !res.last)

    // The final word of a data byte carries no wait before it
    `ASSERT_IMP(a_last_waits, clk, rst_n, res_valid && res.last && res.reg_select,
        res.wait_before_us == 16'd0)

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_lcdns_checker (.*);

/* verif/lcdns_pulse_checker.sv */
`timescale 1ns / 100ps
// Checker for the character LCD nibble sequencer: tracks register writes,
// predicts the enable pulse words of each request and compares them in order.
// Depends on lcdns_pkg only.
module lcdns_pulse_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  lcdns_pkg::req_word_t req,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  lcdns_pkg::res_word_t res,
    output int                   fail_count,
    output int                   pending_count
);

    localparam logic [7:0] DDRAM_SET = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'h40;
    localparam int         REPORT_LIMIT = 10;

    // Register copies; the enable pulse time shapes no word
    logic [3:0]  pulse_time_us;
    logic [7:0]  byte_wait_us;
    logic [15:0] slow_wait_us;
    logic [15:0] power_on_us;

    lcdns_pkg::res_word_t pulse_q[$];
    lcdns_pkg::res_word_t want;

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic lcdns_pkg::res_word_t make_pulse(input logic [3:0] nib,
                                                        input logic rs,
                                                        input logic [15:0] pre_wait,
                                                        input logic [15:0] post_wait,
                                                        input logic last_flag);
        lcdns_pkg::res_word_t w;
        w.nibble         = nib;
        w.reg_select     = rs;
        w.wait_before_us = pre_wait;
        w.wait_after_us  = post_wait;
        w.last           = last_flag;
        return w;
    endfunction

    // Queue the two nibbles of a byte; clear and home commands add the slow wait
    task automatic queue_byte_pulses(input logic [7:0] b, input logic rs,
                                     input logic last_flag);
        logic [16:0] sum;
        logic [15:0] after;
        after = {8'd0, byte_wait_us};
        if (!rs && (b == lcdns_pkg::CMD_CLEAR || b == lcdns_pkg::CMD_HOME))
        begin
            sum   = {9'd0, byte_wait_us} + {1'b0, slow_wait_us};
            after = sum[16] ? 16'hFFFF : sum[15:0];
        end
        pulse_q.push_back(make_pulse(b[7:4], rs, 16'd0, 16'd0, 1'b0));
        pulse_q.push_back(make_pulse(b[3:0], rs, 16'd0, after, last_flag));
    endtask

    // Expand one request into its pulse words
    task automatic queue_request_pulses(input lcdns_pkg::req_word_t r);
        logic [7:0] addr;
        case (r.req_type)
            lcdns_pkg::REQ_INIT:
            begin
                pulse_q.push_back(make_pulse(lcdns_pkg::INIT_WAKE_NIBBLE, 1'b0, power_on_us,
                                             lcdns_pkg::INIT_FIRST_WAIT, 1'b0));
                pulse_q.push_back(make_pulse(lcdns_pkg::INIT_WAKE_NIBBLE, 1'b0, 16'd0,
                                             lcdns_pkg::INIT_SECOND_WAIT, 1'b0));
                pulse_q.push_back(make_pulse(lcdns_pkg::INIT_WAKE_NIBBLE, 1'b0, 16'd0,
                                             {8'd0, byte_wait_us}, 1'b0));
                pulse_q.push_back(make_pulse(lcdns_pkg::INIT_4BIT_NIBBLE, 1'b0, 16'd0,
                                             {8'd0, byte_wait_us}, 1'b0));
                queue_byte_pulses(lcdns_pkg::CMD_FUNC_4BIT, 1'b0, 1'b0);
                queue_byte_pulses(lcdns_pkg::CMD_DISP_OFF, 1'b0, 1'b0);
                queue_byte_pulses(lcdns_pkg::CMD_CLEAR, 1'b0, 1'b0);
                queue_byte_pulses(lcdns_pkg::CMD_ENTRY, 1'b0, 1'b0);
                queue_byte_pulses(lcdns_pkg::CMD_DISP_ON, 1'b0, 1'b1);
            end
            lcdns_pkg::REQ_CMD:
                queue_byte_pulses(r.byte_value, 1'b0, 1'b1);
            lcdns_pkg::REQ_DATA:
                queue_byte_pulses(r.byte_value, 1'b1, 1'b1);
            default:
            begin
                addr = DDRAM_SET | ((r.cursor_row ? ROW1_BASE : 8'h00) +
                                    {2'b00, r.cursor_col});
                queue_byte_pulses(addr, 1'b0, 1'b1);
            end
        endcase
    endtask

    // Compare accepted words, then predict from accepted requests, then track writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_time_us = 4'd1;
            byte_wait_us  = lcdns_pkg::BYTE_WAIT_RESET;
            slow_wait_us  = lcdns_pkg::SLOW_WAIT_RESET;
            power_on_us   = lcdns_pkg::POWER_ON_RESET;
            pulse_q.delete();
            pending_count = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (pulse_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected pulse word nib=%h rs=%b before=%0d after=%0d last=%b",
                                 res.nibble, res.reg_select, res.wait_before_us,
                                 res.wait_after_us, res.last);
                end
                else
                begin
                    want = pulse_q.pop_front();
                    if (res.nibble !== want.nibble || res.reg_select !== want.reg_select ||
                        res.wait_before_us !== want.wait_before_us ||
                        res.wait_after_us !== want.wait_after_us || res.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"pulse mismatch: expected nib=%h rs=%b before=%0d ",
                                      "after=%0d last=%b, got nib=%h rs=%b before=%0d ",
                                      "after=%0d last=%b"},
                                     want.nibble, want.reg_select, want.wait_before_us,
                                     want.wait_after_us, want.last,
                                     res.nibble, res.reg_select, res.wait_before_us,
                                     res.wait_after_us, res.last);
                    end
                end
            end
            if (req_valid && req_ready)
                queue_request_pulses(req);
            if (cfg_we)
            begin
                case (cfg_index)
                    lcdns_pkg::CFG_ENABLE_PULSE: pulse_time_us = cfg_wdata[3:0];
                    lcdns_pkg::CFG_BYTE_WAIT:    byte_wait_us  = cfg_wdata[7:0];
                    lcdns_pkg::CFG_SLOW_WAIT:    slow_wait_us  = cfg_wdata;
                    default:                     power_on_us   = cfg_wdata;
                endcase
            end
            pending_count = pulse_q.size();
        end
    end

endmodule

/* verif/tb_char_lcd_nibble_sequencer.sv */
`timescale 1ns / 100ps
// Testbench top for the character LCD nibble sequencer: drives requests,
// register writes and result back-pressure, and reports the verdict.
// Depends on lcdns_pkg, lcdns_pulse_checker and char_lcd_nibble_sequencer.
module tb_char_lcd_nibble_sequencer;

    localparam int PHASES       = 5;
    localparam int RANDOM_WORDS = 20;

    // Receiver stall styles
    localparam int READY_ALWAYS   = 0;
    localparam int READY_RANDOM   = 1;
    localparam int READY_PERIODIC = 2;
    localparam int READY_LONG_GAP = 3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [15:0]          cfg_wdata;
    logic                 req_valid;
    logic                 req_ready;
    lcdns_pkg::req_word_t req;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    lcdns_pkg::res_word_t res;

    int          fail_count;
    int          pending_count;
    int          burst_left;
    int          gap;
    int          stall_style;
    int          ready_cycle = 0;

    char_lcd_nibble_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    lcdns_pulse_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result channel in a style picked at random from the four above
    always @(negedge clk)
    begin
        if (ready_cycle % 40 == 0)
            stall_style = $urandom_range(READY_ALWAYS, READY_LONG_GAP);
        case (stall_style)
            READY_ALWAYS:   res_ready = 1'b1;
            READY_RANDOM:   res_ready = ($urandom_range(0, 3) != 0);
            READY_PERIODIC: res_ready = ((ready_cycle % 5) < 3);
            default:        res_ready = ((ready_cycle % 16) >= 10);
        endcase
        ready_cycle++;
    end

    // Give up after a generous fixed time
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic lcdns_pkg::req_word_t make_req(input logic [1:0] kind,
                                                      input logic [7:0] b,
                                                      input logic row,
                                                      input logic [5:0] col);
        lcdns_pkg::req_word_t w;
        w.req_type   = kind;
        w.byte_value = b;
        w.cursor_row = row;
        w.cursor_col = col;
        return w;
    endfunction

    // Random request; init is rare, clear and home show up often among commands
    function automatic lcdns_pkg::req_word_t random_req();
        lcdns_pkg::req_word_t w;
        int                   pick;
        w    = make_req(lcdns_pkg::REQ_CMD, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            w.req_type = lcdns_pkg::REQ_INIT;
        else if (pick < 38)
            w.req_type = lcdns_pkg::REQ_CMD;
        else if (pick < 73)
            w.req_type = lcdns_pkg::REQ_DATA;
        else
            w.req_type = lcdns_pkg::REQ_CURSOR;
        if (w.req_type == lcdns_pkg::REQ_CMD && $urandom_range(0, 4) == 0)
            w.byte_value = $urandom_range(0, 1) ? lcdns_pkg::CMD_CLEAR : lcdns_pkg::CMD_HOME;
        return w;
    endfunction

    // Present one word, hold it until taken, then pace the next burst
    task automatic send_word(input lcdns_pkg::req_word_t w);
        req       = w;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Drop valid, wait for every pulse to arrive, then let the block settle
    task automatic drain();
        req_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input logic [3:0] pulse_us, input logic [7:0] byte_us,
                                input logic [15:0] slow_us, input logic [15:0] power_us);
        cfg_we    = 1'b1;
        cfg_index = lcdns_pkg::CFG_ENABLE_PULSE;
        cfg_wdata = {12'd0, pulse_us};
        @(negedge clk);
        cfg_index = lcdns_pkg::CFG_BYTE_WAIT;
        cfg_wdata = {8'd0, byte_us};
        @(negedge clk);
        cfg_index = lcdns_pkg::CFG_SLOW_WAIT;
        cfg_wdata = slow_us;
        @(negedge clk);
        cfg_index = lcdns_pkg::CFG_POWER_ON;
        cfg_wdata = power_us;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = lcdns_pkg::CFG_ENABLE_PULSE;
        cfg_wdata  = 16'd0;
        req_valid  = 1'b0;
        req        = '0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words at reset settings: extremes, clear/home, data bytes
        // that look like clear/home, cursor corners
        send_word(make_req(lcdns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CMD, 8'h00, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CMD, 8'hFF, 1'b1, 6'd63));
        send_word(make_req(lcdns_pkg::REQ_CMD, lcdns_pkg::CMD_CLEAR, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CMD, lcdns_pkg::CMD_HOME, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_DATA, 8'h00, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_DATA, 8'hFF, 1'b1, 6'd63));
        send_word(make_req(lcdns_pkg::REQ_DATA, lcdns_pkg::CMD_CLEAR, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_DATA, lcdns_pkg::CMD_HOME, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CURSOR, 8'h00, 1'b0, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CURSOR, 8'h00, 1'b0, 6'd63));
        send_word(make_req(lcdns_pkg::REQ_CURSOR, 8'hFF, 1'b1, 6'd0));
        send_word(make_req(lcdns_pkg::REQ_CURSOR, 8'hFF, 1'b1, 6'd63));

        // Each phase: new register settings, the slow-wait words, then random words
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == 0)
                write_config(4'd15, 8'd255, 16'hFFFF, 16'hFFFF);
            else if (p == 1)
                write_config(4'd1, 8'd0, 16'd0, 16'd0);
            else if (p == 2)
                write_config(4'($urandom_range(1, 15)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(65280, 65535)), 16'($urandom_range(0, 65535)));
            else
                write_config(4'($urandom_range(1, 15)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            @(negedge clk);
            send_word(make_req(lcdns_pkg::REQ_INIT, 8'h00, 1'b0, 6'd0));
            send_word(make_req(lcdns_pkg::REQ_CMD, lcdns_pkg::CMD_CLEAR, 1'b1, 6'd0));
            send_word(make_req(lcdns_pkg::REQ_CMD, lcdns_pkg::CMD_HOME, 1'b0, 6'd0));
            for (int i = 0; i < RANDOM_WORDS; i++)
                send_word(random_req());
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* char_lcd_nibble_sequencer.f */
+incdir+hw/rtl
hw/rtl/lcdns_pkg.sv
hw/rtl/lcdns_ctrl.sv
hw/rtl/lcdns_dpath.sv
hw/rtl/char_lcd_nibble_sequencer.sv
hw/rtl/lcdns_checker.sv
verif/lcdns_pulse_checker.sv
verif/tb_char_lcd_nibble_sequencer.sv
